FILE: hw/rtl/lagrange_interpolant_eval_top_defines.svh
// Assertion macros used by the checker file.
`ifndef LAGRANGE_INTERPOLANT_EVAL_TOP_DEFINES_SVH
`define LAGRANGE_INTERPOLANT_EVAL_TOP_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define LIE_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define LIE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/lie_pkg.sv
package lie_pkg;

  localparam int unsigned NodeW  = 16;
  localparam int unsigned ValueW = 32;
  localparam int unsigned RecipW = 32;
  // A basis weight is clamped to +-(2^32 - 1), which needs 33 signed bits; WeightW gives 34.
  localparam int unsigned WeightW = 34;
  localparam int unsigned SumW    = 48;
  localparam int unsigned FracShift  = 14;
  localparam int unsigned RecipShift = 24;
  localparam logic signed [RecipW-1:0] RecipOne = 32'sd16777216;
  localparam logic signed [WeightW-1:0] WLimit  = 34'sd4294967295;

  // States of the reciprocal walk.
  typedef enum logic [1:0] {
    RC_IDLE,
    RC_CHECK,
    RC_START,
    RC_WAIT
  } rc_state_t;

  // Control bits that travel down the cell chain with one item.
  typedef struct packed {
    logic valid;
    logic sat;
    logic bad;
  } lie_ctl_t;

  // Clamp a wide product, already shifted, to the weight range.
  function automatic logic signed [WeightW-1:0] clamp_weight(
    input logic signed [RecipW+NodeW+WeightW-1:0] v, output logic hit);
    hit = 1'b0;
    if (v > $signed({{(RecipW+NodeW){1'b0}}, WLimit})) begin
      hit = 1'b1;
      return WLimit;
    end
    if (v < -$signed({{(RecipW+NodeW){1'b0}}, WLimit})) begin
      hit = 1'b1;
      return -WLimit;
    end
    return v[WeightW-1:0];
  endfunction

endpackage

FILE: hw/rtl/lie_div.sv
// Sequential signed divider: quotient of a 64-bit dividend by a 17-bit divisor,
// truncated toward zero, one quotient bit per cycle.
module lie_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] dividend,
  input  logic signed [16:0] divisor,
  output logic               done,
  output logic signed [63:0] quotient
);
  import lie_pkg::*;

  logic [63:0] quo;
  logic [63:0] quo_next;
  logic [17:0] rem;
  logic [17:0] rem_next;
  logic [16:0] dmag;
  logic        neg;
  logic [6:0]  count;
  logic        busy;
  logic [17:0] trial;

  always_comb begin
    trial    = {rem[16:0], quo[63]};
    rem_next = trial;
    quo_next = {quo[62:0], 1'b0};
    if (trial >= {1'b0, dmag}) begin
      rem_next    = trial - {1'b0, dmag};
      quo_next[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= 7'd64;
      end else if (busy) begin
        count <= count - 7'd1;
        if (count == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo  <= dividend[63] ? 64'(-dividend) : dividend;
      dmag <= divisor[16] ? 17'(-divisor) : divisor;
      neg  <= dividend[63] ^ divisor[16];
      rem  <= '0;
    end else if (busy) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

  assign quotient = neg ? -$signed(quo) : $signed(quo);

endmodule

FILE: hw/rtl/lie_recip.sv
// Rebuilds the reciprocal denominators and the degenerate flag from the
// nodes after reset and after each node write.
module lie_recip #(
  parameter int unsigned NODES = 4
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       kick,
  input  logic signed [NODES-1:0][lie_pkg::NodeW-1:0] nodes,
  output logic signed [NODES-1:0][lie_pkg::RecipW-1:0] recip,
  output logic                                       degenerate
);
  import lie_pkg::*;

  localparam int unsigned IdxW = (NODES > 1) ? $clog2(NODES) : 1;

  rc_state_t state;
  rc_state_t state_next;
  logic [IdxW-1:0] q_idx;
  logic [IdxW-1:0] p_idx;
  logic signed [RecipW-1:0] acc;
  logic dup;
  logic div_start;
  logic div_done;
  logic signed [63:0] div_q;
  logic signed [16:0] diff;
  logic last_p;
  logic last_q;
  logic skip_p;
  logic signed [RecipW-1:0] clamped;

  always_comb begin
    dup = 1'b0;
    for (int a = 0; a < NODES; a++) begin
      for (int b = a + 1; b < NODES; b++) begin
        if (nodes[a] == nodes[b]) begin
          dup = 1'b1;
        end
      end
    end
  end

  assign diff   = 17'($signed(nodes[q_idx])) - 17'($signed(nodes[p_idx]));
  assign skip_p = (p_idx == q_idx);
  assign last_p = (p_idx == IdxW'(NODES - 1));
  assign last_q = (q_idx == IdxW'(NODES - 1));

  always_comb begin
    if (div_q > 64'sd2147483647) begin
      clamped = 32'sh7fffffff;
    end else if (div_q < -64'sd2147483648) begin
      clamped = 32'sh80000000;
    end else begin
      clamped = div_q[RecipW-1:0];
    end
  end

  lie_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (64'(acc) <<< FracShift),
    .divisor  (diff),
    .done     (div_done),
    .quotient (div_q)
  );

  // The walk falls back to idle once the last entry has been written, or at once when two nodes are equal.
  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    unique case (state)
      RC_IDLE:  if (kick) state_next = RC_CHECK;
      RC_CHECK: state_next = dup ? RC_IDLE : RC_START;
      RC_START: begin
        if (skip_p) begin
          if (last_p && last_q) state_next = RC_IDLE;
        end else begin
          div_start  = 1'b1;
          state_next = RC_WAIT;
        end
      end
      RC_WAIT:  if (div_done) state_next = (last_p && last_q) ? RC_IDLE : RC_START;
      default:  state_next = RC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= RC_CHECK;
    end else if (kick) begin
      state <= RC_CHECK;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      degenerate <= 1'b0;
      q_idx      <= '0;
      p_idx      <= '0;
      acc        <= RecipOne;
    end else if (kick) begin
      q_idx <= '0;
      p_idx <= '0;
      acc   <= RecipOne;
    end else begin
      priority case (state)
        RC_CHECK: begin
          degenerate <= dup;
          q_idx      <= '0;
          p_idx      <= '0;
          acc        <= RecipOne;
          if (dup) begin
            for (int k = 0; k < NODES; k++) recip[k] <= '0;
          end
        end
        RC_START: begin
          if (skip_p) begin
            if (last_p) begin
              recip[q_idx] <= acc;
              acc          <= RecipOne;
              p_idx        <= '0;
              q_idx        <= q_idx + IdxW'(1);
            end else begin
              p_idx <= p_idx + IdxW'(1);
            end
          end
        end
        RC_WAIT: begin
          if (div_done) begin
            if (last_p) begin
              recip[q_idx] <= clamped;
              acc          <= RecipOne;
              p_idx        <= '0;
              q_idx        <= q_idx + IdxW'(1);
            end else begin
              acc   <= clamped;
              p_idx <= p_idx + IdxW'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: hw/rtl/lie_cell.sv
// One cell of the weight chain: multiplies every lane's weight by
// (r - x_p) for its own node p, floors by 2^14 and clamps. Lane p is skipped.
module lie_cell #(
  parameter int unsigned NODES = 4,
  parameter int unsigned P     = 0
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          advance,
  input  logic signed [lie_pkg::NodeW-1:0]              node_p,
  input  lie_pkg::lie_ctl_t                             ctl_in,
  input  logic signed [lie_pkg::NodeW-1:0]              point_in,
  input  logic signed [NODES-1:0][lie_pkg::ValueW-1:0]  values_in,
  input  logic signed [NODES-1:0][lie_pkg::WeightW-1:0] w_in,
  output lie_pkg::lie_ctl_t                             ctl_out,
  output logic signed [lie_pkg::NodeW-1:0]              point_out,
  output logic signed [NODES-1:0][lie_pkg::ValueW-1:0]  values_out,
  output logic signed [NODES-1:0][lie_pkg::WeightW-1:0] w_out
);
  import lie_pkg::*;

  localparam int unsigned ProdW = RecipW + NodeW + WeightW;

  logic signed [NodeW:0] dr;
  logic signed [NODES-1:0][WeightW-1:0] w_new;
  logic [NODES-1:0] hit;

  assign dr = (NodeW+1)'(point_in) - (NodeW+1)'(node_p);

  always_comb begin
    for (int q = 0; q < NODES; q++) begin
      logic signed [ProdW-1:0] prod;
      prod = ProdW'($signed(w_in[q])) * ProdW'(dr);
      if (q == P) begin
        w_new[q] = w_in[q];
        hit[q]   = 1'b0;
      end else begin
        w_new[q] = clamp_weight(prod >>> FracShift, hit[q]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (advance) begin
      ctl_out.valid <= ctl_in.valid;
      ctl_out.sat   <= ctl_in.sat | (|hit);
      ctl_out.bad   <= ctl_in.bad;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      point_out  <= point_in;
      values_out <= values_in;
      w_out      <= w_new;
    end
  end

endmodule

FILE: hw/rtl/lagrange_interpolant_eval_top.sv
// Path: each transfer is registered in the entry stage, the cell chain, the term
// stage and the output register. Throughput: one transfer per cycle while no
// reciprocal walk holds the input off; the whole pipe stalls only when the
// output register is full and not taken. Reset: synchronous, active high; nodes
// return to equispaced values and the reciprocal walk (NODES*(NODES-1) divides)
// runs. Input is refused until the WalkCycles counter runs out, which covers it.
module lagrange_interpolant_eval_top #(
  parameter int unsigned NODES = 4
) (
  input  logic                             clk,
  input  logic                             rst,
  // s_tdata fields from bit 0: point[15:0], value_0 .. value_{NODES-1}, 32 bits each.
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [16+32*NODES-1:0]           s_tdata,
  // m_tdata fields from bit 0: interpolated[31:0], saturated, bad_nodes, zero pad.
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [39:0]                      m_tdata,
  input  logic                             cfg_we,
  input  logic [7:0]                       cfg_index,
  input  logic [15:0]                      cfg_data
);
  import lie_pkg::*;

  localparam int unsigned Stages = NODES + 1;

  logic signed [NODES-1:0][NodeW-1:0] nodes;
  logic signed [NODES-1:0][NodeW-1:0] reset_nodes;
  logic signed [NODES-1:0][RecipW-1:0] recip;
  logic degenerate;
  logic kick;
  logic ready_cfg;

  // Equispaced reset nodes from -1.0 to +1.0, rounded to nearest.
  for (genvar g = 0; g < NODES; g++) begin : g_reset_node
    localparam int ResetX = -16384 + (2 * 32768 * g + (NODES - 1)) / (2 * (NODES - 1));
    assign reset_nodes[g] = NodeW'(ResetX);
  end

  // Node registers; each valid write restarts the reciprocal walk.
  assign kick = cfg_we && (cfg_index < 8'(NODES));
  always_ff @(posedge clk) begin
    if (rst) begin
      nodes <= reset_nodes;
    end else if (kick) begin
      nodes[cfg_index[$clog2(NODES)-1:0]] <= cfg_data;
    end
  end

  // The walk takes a bounded number of cycles; the input waits that long.
  localparam int unsigned WalkCycles = NODES * (NODES - 1) * 68 + NODES + 8;
  logic [15:0] busy_cnt;
  always_ff @(posedge clk) begin
    if (rst || kick) begin
      busy_cnt <= 16'(WalkCycles);
    end else if (busy_cnt != '0) begin
      busy_cnt <= busy_cnt - 16'd1;
    end
  end
  assign ready_cfg = (busy_cnt == '0);

  lie_recip #(.NODES(NODES)) u_recip (
    .clk        (clk),
    .rst        (rst),
    .kick       (kick),
    .nodes      (nodes),
    .recip      (recip),
    .degenerate (degenerate)
  );

  // Pipeline advances whenever the output register is free or taken.
  logic advance;
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = advance && ready_cfg;

  lie_ctl_t ctl [Stages];
  logic signed [NodeW-1:0] pt [Stages];
  logic signed [NODES-1:0][ValueW-1:0] vals [Stages];
  logic signed [NODES-1:0][WeightW-1:0] wts [Stages];

  // Entry stage: load weights from the reciprocals.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl[0] <= '0;
    end else if (advance) begin
      ctl[0].valid <= s_tvalid && s_tready;
      ctl[0].sat   <= 1'b0;
      ctl[0].bad   <= degenerate;
    end
  end
  always_ff @(posedge clk) begin
    if (advance) begin
      pt[0] <= s_tdata[NodeW-1:0];
      for (int q = 0; q < NODES; q++) begin
        vals[0][q] <= s_tdata[NodeW + ValueW*q +: ValueW];
        wts[0][q]  <= WeightW'($signed(recip[q]));
      end
    end
  end

  for (genvar p = 0; p < NODES; p++) begin : g_cell
    lie_cell #(.NODES(NODES), .P(p)) u_cell (
      .clk        (clk),
      .rst        (rst),
      .advance    (advance),
      .node_p     (nodes[p]),
      .ctl_in     (ctl[p]),
      .point_in   (pt[p]),
      .values_in  (vals[p]),
      .w_in       (wts[p]),
      .ctl_out    (ctl[p+1]),
      .point_out  (pt[p+1]),
      .values_out (vals[p+1]),
      .w_out      (wts[p+1])
    );
  end

  // Term stage: w_q * u_q floored by 2^24, summed exactly.
  logic signed [SumW-1:0] terms [NODES];
  always_ff @(posedge clk) begin
    if (advance) begin
      for (int q = 0; q < NODES; q++) begin
        logic signed [WeightW+ValueW-1:0] prod;
        prod = (WeightW+ValueW)'($signed(wts[NODES][q]))
             * (WeightW+ValueW)'($signed(vals[NODES][q]));
        terms[q] <= SumW'(prod >>> RecipShift);
      end
    end
  end

  lie_ctl_t ctl_t;
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_t <= '0;
    end else if (advance) begin
      ctl_t <= ctl[NODES];
    end
  end

  logic signed [SumW-1:0] total;
  logic [31:0] result;
  logic sat_sum;
  always_comb begin
    total = '0;
    for (int q = 0; q < NODES; q++) total = total + terms[q];
    sat_sum = 1'b0;
    if (total > 48'sd2147483647) begin
      result  = 32'h7fffffff;
      sat_sum = 1'b1;
    end else if (total < -48'sd2147483648) begin
      result  = 32'h80000000;
      sat_sum = 1'b1;
    end else begin
      result = total[31:0];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= ctl_t.valid;
    end
  end
  always_ff @(posedge clk) begin
    if (advance) begin
      if (ctl_t.bad) begin
        m_tdata <= {6'd0, 1'b1, 1'b0, 32'd0};
      end else begin
        m_tdata <= {6'd0, 1'b0, ctl_t.sat | sat_sum, result};
      end
    end
  end

endmodule

FILE: hw/rtl/lie_checker.sv
`include "lagrange_interpolant_eval_top_defines.svh"
// Port-level checks on the evaluator.
module lie_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata
);
  `LIE_ASSERT_NEXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata),
    "output changed while stalled")
  `LIE_ASSERT_IMPL(a_bad_zero, clk, rst, m_tvalid && m_tdata[33], m_tdata[31:0] == 32'd0,
    "bad nodes with nonzero result")
  `LIE_ASSERT_IMPL(a_pad, clk, rst, m_tvalid, m_tdata[39:34] == 6'd0, "pad bits set")
  `LIE_ASSERT_IMPL(a_stall_ready, clk, rst, m_tvalid && !m_tready, !s_tready,
    "input taken while output stalled")
endmodule

bind lagrange_interpolant_eval_top lie_checker u_lie_checker (
  .clk(clk), .rst(rst), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
